// File: design/bts_pkg.sv
package bts_pkg;

	// custom tune store
	localparam int CUSTOM_DEPTH = 32;
	localparam int CUST_AW = (CUSTOM_DEPTH > 1) ? $clog2(CUSTOM_DEPTH) : 1;

	typedef logic [11:0] hz_t;

	typedef struct packed {
		logic [7:0] code;
		logic [7:0] ticks;
	} entry_t;

	// operations
	typedef logic [1:0] op_t;
	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_START = 2'd1;
	localparam op_t OP_WRITE = 2'd2;

	// configuration register indexes
	localparam logic CFG_END_CODE  = 1'b0;
	localparam logic CFG_MUTE_CODE = 1'b1;

	localparam logic [7:0] END_CODE_RST  = 8'h00;
	localparam logic [7:0] MUTE_CODE_RST = 8'hFF;

	localparam logic [2:0] NUM_ROM_TUNES = 3'd5;
	localparam logic [2:0] TUNE_CUSTOM   = 3'd5;
	localparam logic [5:0] ROM_LEN       = 6'd20;
	localparam logic [5:0] POS_MAX       = 6'd63;

	localparam logic [7:0] DEFAULT_CODE  = 8'h35;
	localparam logic [7:0] DEFAULT_TICKS = 8'h02;

	localparam hz_t FREQ_MUTE  = 12'd1;
	localparam hz_t FREQ_OTHER = 12'd3934;

	localparam hz_t NOTE_HZ [4][7] = '{
		'{12'd262,  12'd294,  12'd330,  12'd349,  12'd392,  12'd440,  12'd494},
		'{12'd523,  12'd587,  12'd659,  12'd698,  12'd784,  12'd880,  12'd988},
		'{12'd1046, 12'd1175, 12'd1318, 12'd1397, 12'd1568, 12'd1760, 12'd1967},
		'{12'd2092, 12'd2350, 12'd2636, 12'd2794, 12'd3136, 12'd3520, 12'd3934}
	};

	// ROM tunes alternate two codes at a fixed duration
	localparam logic [7:0] ROM_EVEN  [5] = '{8'h33, 8'h31, 8'h33, 8'h31, 8'h27};
	localparam logic [7:0] ROM_ODD   [5] = '{8'h31, 8'h27, 8'h31, 8'h27, 8'h25};
	localparam logic [7:0] ROM_TICKS [5] = '{8'h02, 8'h03, 8'h02, 8'h03, 8'h02};

endpackage

// File: design/bts_note_lut.sv
module bts_note_lut
	import bts_pkg::*;
(
	input  logic [7:0] code,
	input  logic [7:0] mute_code,
	output hz_t        hz
);

	logic [2:0] deg_idx;
	logic       is_note;

	assign deg_idx = code[2:0] - 3'd1;
	// octave nibble 0..3, degree 1..7
	assign is_note = (code[7:6] == 2'b00) && (code[3:0] >= 4'd1) && (code[3:0] <= 4'd7);

	always_comb begin
		if (code == mute_code) begin
			hz = FREQ_MUTE;
		end else if (is_note) begin
			hz = NOTE_HZ[code[5:4]][deg_idx];
		end else begin
			hz = FREQ_OTHER;
		end
	end

endmodule

// File: design/buzzer_tune_sequencer_top.sv
// Buzzer tune sequencer. Each input beat (tick, start tune, or custom entry
// write) is accepted on a handshake and yields exactly one result beat giving
// the tone frequency, drive enable, finished flag and whether a new note was
// loaded. The state update and note lookup sit between the state registers,
// which also serve as the output register, so a new beat is accepted every
// cycle while the consumer takes results; in_ready only drops while a result
// is held unread. The custom tune store is a flip-flop array read at the
// current play position; an entry must be written before it is played.
module buzzer_tune_sequencer_top
	import bts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [2:0] tune_select,
	input  logic [4:0] entry_index,
	input  logic [7:0] note_code,
	input  logic [7:0] note_ticks,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] tone_hz,
	output logic        tone_on,
	output logic        finished,
	output logic        tone_loaded
);

	logic [7:0] end_code_q;
	logic [7:0] mute_code_q;

	entry_t custom_q [CUSTOM_DEPTH];

	logic [2:0]  tune_q;
	logic [5:0]  pos_q;
	logic [7:0]  ticks_q;
	hz_t         freq_q;
	logic        en_q;
	logic        done_q;
	logic        loaded_q;
	logic        out_valid_q;

	logic [2:0]  tune_d;
	logic [5:0]  pos_d;
	logic [7:0]  ticks_d;
	hz_t         freq_d;
	logic        en_d;
	logic        done_d;
	logic        loaded_d;

	logic        in_acc;
	logic [2:0]  fetch_tune;
	logic [5:0]  fetch_pos;
	logic [CUST_AW+5:0] pos_ext;
	logic [CUST_AW+5:0] widx_ext;
	entry_t      entry;
	hz_t         entry_hz;
	logic        is_end;
	logic [5:0]  pos_adv;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q  <= END_CODE_RST;
			mute_code_q <= MUTE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_END_CODE:  end_code_q  <= cfg_data;
				CFG_MUTE_CODE: mute_code_q <= cfg_data;
				default:       end_code_q  <= end_code_q;
			endcase
		end
	end

	// custom tune store, no reset
	assign widx_ext = (CUST_AW+6)'(entry_index);

	always_ff @(posedge clk) begin
		if (in_acc && (op == OP_WRITE) && (widx_ext < (CUST_AW+6)'(CUSTOM_DEPTH))) begin
			custom_q[widx_ext[CUST_AW-1:0]] <= '{code: note_code, ticks: note_ticks};
		end
	end

	// a start always fetches position 0 of the selected tune
	assign fetch_tune = (op == OP_START) ? tune_select : tune_q;
	assign fetch_pos  = (op == OP_START) ? 6'd0 : pos_q;
	assign pos_ext    = (CUST_AW+6)'(fetch_pos);

	always_comb begin
		entry = '0;
		if (fetch_tune < NUM_ROM_TUNES) begin
			if (fetch_pos < ROM_LEN) begin
				entry.code  = fetch_pos[0] ? ROM_ODD[fetch_tune] : ROM_EVEN[fetch_tune];
				entry.ticks = ROM_TICKS[fetch_tune];
			end
		end else if (fetch_tune == TUNE_CUSTOM) begin
			if (pos_ext < (CUST_AW+6)'(CUSTOM_DEPTH)) begin
				entry = custom_q[pos_ext[CUST_AW-1:0]];
			end
		end else if (fetch_pos == 6'd0) begin
			entry.code  = DEFAULT_CODE;
			entry.ticks = DEFAULT_TICKS;
		end
	end

	bts_note_lut u_note_lut (
		.code      (entry.code),
		.mute_code (mute_code_q),
		.hz        (entry_hz)
	);

	assign is_end  = (entry.code == end_code_q);
	assign pos_adv = (fetch_pos < POS_MAX) ? fetch_pos + 6'd1 : fetch_pos;

	always_comb begin
		tune_d   = tune_q;
		pos_d    = pos_q;
		ticks_d  = ticks_q;
		freq_d   = freq_q;
		en_d     = en_q;
		done_d   = done_q;
		loaded_d = 1'b0;
		case (op)
			OP_TICK: begin
				if (!done_q) begin
					if (ticks_q != 8'd0) begin
						ticks_d = ticks_q - 8'd1;
					end else if (is_end) begin
						en_d   = 1'b0;
						done_d = 1'b1;
					end else begin
						freq_d   = entry_hz;
						ticks_d  = entry.ticks;
						pos_d    = pos_adv;
						loaded_d = 1'b1;
					end
				end
			end
			OP_START: begin
				tune_d = tune_select;
				pos_d  = 6'd0;
				if (is_end) begin
					en_d   = 1'b0;
					done_d = 1'b1;
				end else begin
					freq_d   = entry_hz;
					ticks_d  = entry.ticks - 8'd1;
					pos_d    = pos_adv;
					en_d     = 1'b1;
					done_d   = 1'b0;
					loaded_d = 1'b1;
				end
			end
			default: begin
				loaded_d = 1'b0;
			end
		endcase
	end

	// sequencer state doubles as the result register: it only moves on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_q      <= '0;
			pos_q       <= '0;
			ticks_q     <= '0;
			freq_q      <= '0;
			en_q        <= 1'b0;
			done_q      <= 1'b1;
			loaded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				tune_q      <= tune_d;
				pos_q       <= pos_d;
				ticks_q     <= ticks_d;
				freq_q      <= freq_d;
				en_q        <= en_d;
				done_q      <= done_d;
				loaded_q    <= loaded_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign tone_hz     = freq_q;
	assign tone_on     = en_q;
	assign finished    = done_q;
	assign tone_loaded = loaded_q;

`ifndef SYNTHESIS
	a_on_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		en_q |-> !done_q)
		else $error("tone enabled while finished");

	a_loaded_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && loaded_q) |-> (en_q && !done_q))
		else $error("note loaded but not playing");

	a_done_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == OP_TICK) && done_q) |=>
			($stable(pos_q) && $stable(ticks_q) && $stable(freq_q) && !loaded_q))
		else $error("tick changed state after finish");

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted beat produced no result");
`endif

endmodule
